FILE: rtl/gntd_pkg.sv
// ----------------------------------------------------------------------------
// gntd_pkg
// shared constants, codes and word types of the nearest-type distance block
// ----------------------------------------------------------------------------
package gntd_pkg;

  localparam int NUM_ROWS = 64;
  localparam int NUM_COLS = 64;
  localparam int ROW_W    = $clog2(NUM_ROWS);
  localparam int COL_W    = $clog2(NUM_COLS);
  localparam int DIM_W    = 7;
  localparam int TYPE_W   = 4;
  localparam int DIST_W   = 7;
  localparam int STAT_W   = 2;
  localparam int LINE_W   = NUM_COLS * TYPE_W;

  localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(NUM_ROWS);
  localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(NUM_COLS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

  typedef struct packed {
    logic              op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TYPE_W-1:0] cell_type;
    logic [TYPE_W-1:0] query_type;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [STAT_W-1:0] status;
  } out_word_t;

  // row tag that travels alongside a line read from the grid
  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
  } srch_tag_t;

  // per-row outcome of the column search
  typedef struct packed {
    logic             busy;
    logic             vld;
    logic             found;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] cdist;
  } srch_res_t;

endpackage

FILE: rtl/gntd_row_mem.sv
// ----------------------------------------------------------------------------
// gntd_row_mem
// grid store, one line of cell types per row, with a valid bit for each row
// ----------------------------------------------------------------------------
module gntd_row_mem
  import gntd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ROW_W-1:0]  rd_addr_i,
  output logic [LINE_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ROW_W-1:0]  wr_addr_i,
  input  logic [LINE_W-1:0] wr_data_i
);

  logic [LINE_W-1:0]   mem_q [NUM_ROWS];
  logic [LINE_W-1:0]   rd_data_q;
  logic [NUM_ROWS-1:0] row_vld_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  // a row never written reads as all empty
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: rtl/gntd_row_search.sv
// ----------------------------------------------------------------------------
// gntd_row_search
// two-stage search of one grid line for the nearest matching column
// ----------------------------------------------------------------------------
module gntd_row_search
  import gntd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srch_tag_t         tag_i,
  input  logic [LINE_W-1:0] line_i,
  input  logic [TYPE_W-1:0] qtype_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [DIM_W-1:0]  act_cols_i,
  output srch_res_t         res_o
);

  function automatic logic [COL_W-1:0] low_idx(input logic [NUM_COLS-1:0] m);
    logic [NUM_COLS-1:0] v;
    logic [COL_W-1:0]    idx;
    v   = m;
    idx = '0;
    for (int k = COL_W - 1; k >= 0; k--) begin
      if ((v & ((NUM_COLS'(1) << (1 << k)) - NUM_COLS'(1))) == '0) begin
        idx[k] = 1'b1;
        v      = v >> (1 << k);
      end
    end
    return idx;
  endfunction

  logic [NUM_COLS-1:0] left_d, right_d, left_q, right_q, left_rev;
  logic                a_vld_q, b_vld_q, b_found_q;
  logic [ROW_W-1:0]    a_row_q, b_row_q;
  logic [COL_W-1:0]    b_cdist_q, b_cdist_d, hi_idx, lo_idx, dl, dr;
  logic                b_found_d;

  // stage a: match mask split at the query column
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      logic hit;
      hit = (line_i[c*TYPE_W +: TYPE_W] == qtype_i) && (DIM_W'(c) < act_cols_i);
      left_d[c]  = hit && (COL_W'(c) <= col_i);
      right_d[c] = hit && (COL_W'(c) >= col_i);
    end
  end

  // stage b: nearest hit on either side
  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      left_rev[c] = left_q[NUM_COLS-1-c];
    end
    hi_idx    = COL_W'(NUM_COLS - 1) - low_idx(left_rev);
    lo_idx    = low_idx(right_q);
    dl        = col_i - hi_idx;
    dr        = lo_idx - col_i;
    b_found_d = (left_q != '0) || (right_q != '0);
    if (left_q == '0) begin
      b_cdist_d = dr;
    end else if (right_q == '0) begin
      b_cdist_d = dl;
    end else begin
      b_cdist_d = (dl < dr) ? dl : dr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= tag_i.vld;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_row_q   <= tag_i.row;
    left_q    <= left_d;
    right_q   <= right_d;
    b_row_q   <= a_row_q;
    b_found_q <= b_found_d;
    b_cdist_q <= b_cdist_d;
  end

  assign res_o.busy  = a_vld_q | b_vld_q;
  assign res_o.vld   = b_vld_q;
  assign res_o.found = b_found_q;
  assign res_o.row   = b_row_q;
  assign res_o.cdist = b_cdist_q;

endmodule

FILE: rtl/grid_nearest_type_distance.sv
// ----------------------------------------------------------------------------
// grid_nearest_type_distance
// grid of cell type codes with nearest-type city-block distance queries
// ----------------------------------------------------------------------------
// write word: line read, then modify and write back; an ignored write returns to idle at once
// query word: one grid line read and searched per cycle over the active rows,
//   each line passing through a two-stage column search
// out-of-range query: goes straight to the result; one word in flight, not ready while busy
// reset: grid reads as empty at once through per-row valid bits, no clear pass
module grid_nearest_type_distance
  import gntd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WMOD  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [DIM_W-1:0]  rows_q, cols_q, cfg_val;
  in_word_t          item_q;
  logic [ROW_W-1:0]  scan_q, scan_d;
  logic              found_q, found_d, range_q, range_d;
  logic [DIST_W-1:0] best_q, best_d, dsum;
  logic [COL_W-1:0]  rdist;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;
  logic              in_acc, in_inside;
  logic              rd_en, wr_en;
  logic [ROW_W-1:0]  rd_addr;
  logic [LINE_W-1:0] rd_data, wr_data;
  srch_tag_t         tag_q, tag_d;
  srch_res_t         res;

  gntd_row_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (item_q.row),
    .wr_data_i (wr_data)
  );

  gntd_row_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (tag_q),
    .line_i     (rd_data),
    .qtype_i    (item_q.query_type),
    .col_i      (item_q.col),
    .act_cols_i (cols_q),
    .res_o      (res)
  );

  // register value clamped to the grid size, zero taken as one
  always_comb begin
    cfg_val = cfg_wdata_i;
    if (cfg_idx_i == REG_ROWS) begin
      if (cfg_val > ROWS_RST) cfg_val = ROWS_RST;
    end else begin
      if (cfg_val > COLS_RST) cfg_val = COLS_RST;
    end
    if (cfg_val == '0) cfg_val = DIM_W'(1);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_inside  = ({1'b0, in_word_i.row} < rows_q) && ({1'b0, in_word_i.col} < cols_q);

  assign rdist = (res.row > item_q.row) ? (res.row - item_q.row) : (item_q.row - res.row);
  assign dsum  = DIST_W'(res.cdist) + DIST_W'(rdist);

  always_comb begin
    wr_data = rd_data;
    wr_data[item_q.col*TYPE_W +: TYPE_W] = item_q.cell_type;
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    found_d     = found_q;
    best_d      = best_q;
    range_d     = range_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    rd_en       = 1'b0;
    rd_addr     = scan_q;
    wr_en       = 1'b0;
    tag_d.vld   = 1'b0;
    tag_d.row   = scan_q;

    if (res.vld && res.found && (!found_q || dsum < best_q)) begin
      found_d = 1'b1;
      best_d  = dsum;
    end

    case (state_q)
      ST_IDLE: begin
        rd_addr = in_word_i.row;
        if (in_acc) begin
          found_d = 1'b0;
          scan_d  = '0;
          range_d = !in_inside;
          if (in_word_i.op == OP_WRITE) begin
            if (in_inside) begin
              rd_en   = 1'b1;
              state_d = ST_WMOD;
            end
          end else if (in_inside) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_WMOD: begin
        wr_en   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        rd_en     = 1'b1;
        tag_d.vld = 1'b1;
        if ({1'b0, scan_q} == rows_q - DIM_W'(1)) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + ROW_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!tag_q.vld && !res.busy) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (range_q) begin
            out_word_d.status   = STAT_RANGE;
            out_word_d.distance = '0;
          end else if (found_q) begin
            out_word_d.status   = STAT_OK;
            out_word_d.distance = best_q;
          end else begin
            out_word_d.status   = STAT_ABSENT;
            out_word_d.distance = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= ROWS_RST;
      cols_q      <= COLS_RST;
      out_valid_q <= 1'b0;
      tag_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      tag_q       <= tag_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ROWS) begin
          rows_q <= cfg_val;
        end else begin
          cols_q <= cfg_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_word_i;
    scan_q     <= scan_d;
    found_q    <= found_d;
    best_q     <= best_d;
    range_q    <= range_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: bench/tb_grid_nearest_type_distance.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_nearest_type_distance
// self-checking bench for the nearest-type distance grid
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the grid and the active area, works out
// each query's distance and status when the word is accepted, and compares
// every result word field by field in order. A short directed run covers the
// grid corners, largest distances, empty-type queries, ignored writes,
// out-of-range queries and a shrunk area growing back. Random phases follow
// under varied area settings, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_grid_nearest_type_distance;
  import gntd_pkg::*;

  localparam int NUM_PHASES = 12;
  localparam int PHASE_WORDS = 120;
  localparam int SETTLE = 12;

  class grid_scoreboard;
    logic [TYPE_W-1:0] grid [NUM_ROWS][NUM_COLS];
    int unsigned rows_used;
    int unsigned cols_used;
    out_word_t pending[$];
    int errors;

    function new();
      for (int r = 0; r < NUM_ROWS; r++)
        for (int c = 0; c < NUM_COLS; c++)
          grid[r][c] = '0;
      rows_used = NUM_ROWS;
      cols_used = NUM_COLS;
      errors = 0;
    endfunction

    function void set_dim(input logic idx, input logic [DIM_W-1:0] v);
      int unsigned n;
      n = (v == 0) ? 1 : v;
      if (idx == REG_ROWS) rows_used = (n > NUM_ROWS) ? NUM_ROWS : n;
      else cols_used = (n > NUM_COLS) ? NUM_COLS : n;
    endfunction

    function out_word_t nearest_result(input in_word_t w);
      out_word_t res;
      bit found;
      int unsigned best;
      int unsigned d;
      res = '0;
      if (w.row >= rows_used || w.col >= cols_used) begin
        res.status = STAT_RANGE;
        return res;
      end
      found = 1'b0;
      best = 0;
      for (int r = 0; r < rows_used; r++) begin
        for (int c = 0; c < cols_used; c++) begin
          if (grid[r][c] == w.query_type) begin
            d = ((r > w.row) ? r - w.row : w.row - r) + ((c > w.col) ? c - w.col : w.col - c);
            if (!found || d < best) begin
              best = d;
              found = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        res.status = STAT_ABSENT;
      end else begin
        res.distance = (best > 127) ? DIST_W'(127) : DIST_W'(best);
        res.status = STAT_OK;
      end
      return res;
    endfunction

    function void note_word(input in_word_t w);
      if (w.op == OP_WRITE) begin
        if (w.row < rows_used && w.col < cols_used) grid[w.row][w.col] = w.cell_type;
      end else begin
        pending = {pending, nearest_result(w)};
      end
    endfunction

    function void check_result(input out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, distance %0d status %0d",
                 $time, got.distance, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, want.distance, got.distance);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic cfg_idx = REG_ROWS;
  logic [DIM_W-1:0] cfg_wdata = '0;

  grid_scoreboard board = new;
  bit calm = 1'b0;
  int idle_rate = 0;
  int stall_rate = 0;
  int stall_left = 0;
  logic [TYPE_W-1:0] palette [3];

  grid_nearest_type_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check accepted words, stall in bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) board.check_result(out_word);
    if (!rst_ni || calm || stall_rate == 0) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(1, stall_rate) == 1) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_word_t cell_write(input int r, input int c, input int t);
    in_word_t w;
    w.op = OP_WRITE;
    w.row = ROW_W'(r);
    w.col = COL_W'(c);
    w.cell_type = TYPE_W'(t);
    w.query_type = TYPE_W'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic in_word_t cell_query(input int r, input int c, input int q);
    in_word_t w;
    w.op = OP_QUERY;
    w.row = ROW_W'(r);
    w.col = COL_W'(c);
    w.cell_type = TYPE_W'($urandom_range(0, 15));
    w.query_type = TYPE_W'(q);
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    int c;
    int t;
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(0, NUM_ROWS - 1);
      c = $urandom_range(0, NUM_COLS - 1);
    end else begin
      r = $urandom_range(0, board.rows_used - 1);
      c = $urandom_range(0, board.cols_used - 1);
    end
    if ($urandom_range(0, 9) < 4) begin
      t = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 2)] : $urandom_range(0, 15);
      w = cell_query(r, c, t);
    end else begin
      t = ($urandom_range(0, 9) < 8) ? palette[$urandom_range(0, 2)] : $urandom_range(0, 15);
      w = cell_write(r, c, t);
    end
    return w;
  endfunction

  // present one word, return at the edge that takes it
  task automatic send_word(input in_word_t w);
    if (!calm && idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall);
    board.note_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= REG_ROWS;
    cfg_wdata <= rows;
    board.set_dim(REG_ROWS, rows);
    @(posedge clk_i);
    cfg_idx <= REG_COLS;
    cfg_wdata <= cols;
    board.set_dim(REG_COLS, cols);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [DIM_W-1:0] phase_rows [NUM_PHASES];
    logic [DIM_W-1:0] phase_cols [NUM_PHASES];
    phase_rows = '{7'd64, 7'd1, 7'd64, 7'd2, 7'd127, 7'd0,
                   7'd7, 7'd9, 7'd33, 7'd65, 7'd12, 7'd64};
    phase_cols = '{7'd64, 7'd64, 7'd1, 7'd3, 7'd0, 7'd127,
                   7'd5, 7'd2, 7'd40, 7'd17, 7'd65, 7'd64};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty grid, corners and the longest path
    send_word(cell_query(0, 0, 0));
    send_word(cell_query(63, 63, 9));
    send_word(cell_write(63, 63, 15));
    send_word(cell_query(0, 0, 15));
    send_word(cell_write(0, 0, 9));
    send_word(cell_query(63, 63, 9));
    send_word(cell_query(32, 17, 15));
    send_word(cell_write(0, 63, 0));
    send_word(cell_query(63, 0, 0));
    // one row, zero taken as one
    write_dims(7'd0, 7'd127);
    send_word(cell_write(1, 5, 3));
    send_word(cell_query(1, 0, 0));
    send_word(cell_query(0, 63, 15));
    send_word(cell_query(0, 40, 9));
    // one column, rows clamped
    write_dims(7'd65, 7'd1);
    send_word(cell_query(0, 1, 9));
    send_word(cell_query(63, 0, 15));
    send_word(cell_write(10, 3, 4));
    send_word(cell_query(5, 0, 9));
    // area grows back
    write_dims(7'd64, 7'd64);
    send_word(cell_query(60, 60, 15));
    send_word(cell_query(10, 3, 4));
    send_word(cell_write(10, 3, 4));
    send_word(cell_query(20, 60, 4));
    write_dims(7'd1, 7'd1);
    send_word(cell_query(0, 0, 9));
    send_word(cell_write(0, 0, 0));
    send_word(cell_query(0, 0, 9));

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 6 || p == 7)
        write_dims(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 20)));
      else
        write_dims(phase_rows[p], phase_cols[p]);
      for (int k = 0; k < 3; k++) palette[k] = TYPE_W'($urandom_range(0, 15));
      calm = (p == NUM_PHASES - 1);
      idle_rate = (p % 3 == 0) ? 0 : 4;
      stall_rate = (p % 3 == 1) ? 0 : 4;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
        if (p == 2 && n == PHASE_WORDS / 2) drain();
      end
    end

    in_valid <= 1'b0;
    for (int i = 0; i < 100000 && board.pending.size() != 0; i++) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (board.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.pending.size());
      board.errors++;
    end
    if (board.errors == 0)
      $display("grid_nearest_type_distance: match");
    else
      $display("grid_nearest_type_distance: mismatch");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("grid_nearest_type_distance: mismatch");
    $finish;
  end

endmodule
